FILE: sv/tpac_pkg.sv
// ----------------------------------------------------------------------------
// tpac_pkg
// Shared types, codes and constants of the triac phase-angle controller.
// ----------------------------------------------------------------------------
package tpac_pkg;

	localparam int TimerBits = 24;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 24;
	localparam int DivSteps  = 24;
	localparam int DivCntW   = $clog2(DivSteps + 1);

	typedef enum logic [1:0] {
		OP_CROSS    = 2'd0,
		OP_TICK     = 2'd1,
		OP_SET      = 2'd2,
		OP_SET_RAMP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT1  = 3'd1,
		PH_PULSE1 = 3'd2,
		PH_WAIT2  = 3'd3,
		PH_PULSE2 = 3'd4,
		PH_BAD5   = 3'd5,
		PH_BAD6   = 3'd6,
		PH_BAD7   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		REG_BASE_OFFSET = 3'd0,
		REG_HALF_OFFSET = 3'd1,
		REG_PULSE_WIDTH = 3'd2,
		REG_MIN_POWER   = 3'd3,
		REG_MAX_DELAY   = 3'd4,
		REG_REJECT      = 3'd5,
		REG_HALF_MODE   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		CT_IDLE,
		CT_DIV,
		CT_PDLY,
		CT_EXEC,
		CT_OUT
	} ctl_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [23:0] time_us;
		logic [31:0] time_ms;
		logic [7:0]  power_request;
		logic [15:0] ramp_ms;
	} req_t;

	typedef struct packed {
		logic        gate_level;
		logic        gate_written;
		logic [6:0]  power_now;
		logic [23:0] period_us;
		logic [2:0]  fire_state;
		logic        ramp_running;
	} rsp_t;

	typedef struct packed {
		logic capture;   // latch request
		logic div_start; // start ramp divide
		logic div_step;
		logic pdly_calc; // compute phase delay
		logic exec;      // commit state update
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

endpackage

FILE: sv/tpac_if.sv
// ----------------------------------------------------------------------------
// tpac_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface tpac_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/tpac_ctrl.sv
// ----------------------------------------------------------------------------
// tpac_ctrl
// Sequencer: capture, optional ramp divide, phase delay, commit, output.
// ----------------------------------------------------------------------------
module tpac_ctrl import tpac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CT_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CT_IDLE: if (in_valid) state_d = CT_DIV;
			CT_DIV:  if (!sts.need_div || sts.div_done) state_d = CT_PDLY;
			CT_PDLY: state_d = CT_EXEC;
			CT_EXEC: state_d = CT_OUT;
			CT_OUT:  if (out_ready) state_d = CT_IDLE;
			default: state_d = CT_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			CT_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
				cmd.div_start = in_valid;
			end
			CT_DIV:  cmd.div_step = sts.need_div && !sts.div_done;
			CT_PDLY: cmd.pdly_calc = 1'b1;
			CT_EXEC: cmd.exec = 1'b1;
			CT_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: sv/tpac_dp.sv
// ----------------------------------------------------------------------------
// tpac_dp
// Datapath: config registers, controller state, serial ramp divider.
// ----------------------------------------------------------------------------
module tpac_dp import tpac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  req_t                req,
	input  cmd_t                cmd,
	output sts_t                sts,
	output rsp_t                rsp
);

	logic [15:0] base_q, width_q, maxd_q, reject_q;
	logic [23:0] half_off_q;
	logic [6:0]  minp_q;
	logic        hmode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0; half_off_q <= '0; width_q <= '0; minp_q <= '0;
			maxd_q <= '0; reject_q <= '0; hmode_q <= 1'b0;
		end else if (cfg_we) begin
			priority case (cfg_idx)
				REG_BASE_OFFSET: base_q <= cfg_data[15:0];
				REG_HALF_OFFSET: half_off_q <= cfg_data[23:0];
				REG_PULSE_WIDTH: width_q <= cfg_data[15:0];
				REG_MIN_POWER:   minp_q <= cfg_data[6:0];
				REG_MAX_DELAY:   maxd_q <= cfg_data[15:0];
				REG_REJECT:      reject_q <= cfg_data[15:0];
				REG_HALF_MODE:   hmode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// controller state
	phase_t      phase_q;
	logic        gate_q, pend_q, ramp_on_q;
	logic [6:0]  power_q, rfrom_q, rto_q;
	logic [23:0] last_q, period_q, pbegin_q;
	logic [16:0] fdelay_q;
	logic [15:0] rlen_q;
	logic [31:0] rbegin_q;
	logic        written_q;

	req_t        req_q;
	always_ff @(posedge clk) if (cmd.capture) req_q <= req;

	// ramp divider: (mag*el)/len, el < len so quotient < 128
	logic [31:0] el;
	logic        rdown;
	logic [6:0]  mag;
	logic        ramp_tick, ramp_cap, ramp_end;
	assign el = req_q.time_ms - rbegin_q;
	assign rdown = rto_q < rfrom_q;
	assign mag = rdown ? rfrom_q - rto_q : rto_q - rfrom_q;
	assign ramp_tick = (req_q.operation == OP_TICK) && ramp_on_q;
	assign ramp_cap = rbegin_q == '0;
	assign ramp_end = (el >= {16'd0, rlen_q}) || (rlen_q == '0);
	assign sts.need_div = ramp_tick && !ramp_cap && !ramp_end;

	// el < len so product fits in 23 bits
	logic [22:0] prod_q, rem_q;
	logic [6:0]  quo_q;
	logic [DivCntW-1:0] cnt_q;
	logic [23:0] trial;
	assign trial = {rem_q, prod_q[22]} - {8'd0, rlen_q};
	assign sts.div_done = cnt_q == DivCntW'(DivSteps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.div_start) cnt_q <= '0;
		else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.pdly_calc && cnt_q == '0) begin
			prod_q <= '0;
		end else if (cmd.div_step) begin
			if (cnt_q == '0) begin
				prod_q <= {7'd0, el[15:0]} * {16'd0, mag};
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				if (!trial[23]) begin
					rem_q <= trial[22:0];
					quo_q <= {quo_q[5:0], 1'b1};
				end else begin
					rem_q <= {rem_q[21:0], prod_q[22]};
					quo_q <= {quo_q[5:0], 1'b0};
				end
				prod_q <= {prod_q[21:0], 1'b0};
			end
		end
	end

	// first step loads the product, then one quotient bit per step for all
	// 23 product bits; quotient < 100 so only the low 7 bits are kept

	// ramp power after this tick
	logic [6:0]  ramp_pow;
	logic [7:0]  up_sum;
	assign up_sum = {1'b0, rfrom_q} + {1'b0, quo_q};
	always_comb begin
		if (rdown) ramp_pow = rfrom_q - quo_q;
		else ramp_pow = (up_sum > 8'd100) ? 7'd100 : up_sum[6:0];
	end

	logic [6:0] pow_tick;
	assign pow_tick = !ramp_tick || ramp_cap ? power_q : (ramp_end ? rto_q : ramp_pow);

	// phase delay for power after ramp
	logic [22:0] pd_prod_s1;
	logic [15:0] pdly;
	logic [6:0]  pinv;
	assign pinv = (pow_tick >= 7'd100) ? 7'd0 : 7'd100 - pow_tick;
	always_ff @(posedge clk) if (cmd.pdly_calc) pd_prod_s1 <= {7'd0, maxd_q} * {16'd0, pinv};
	// divide by 100: ceil(2^30/100) reciprocal is exact for products below 2^23
	logic [46:0] recip;
	assign recip = {24'd0, pd_prod_s1} * 47'd10737419;
	assign pdly = recip[45:30];

	// next state
	logic [23:0] now, since_last, since_pb;
	logic [6:0]  creq;
	logic [25:0] limit;
	assign now = req_q.time_us;
	assign since_last = now - last_q;
	assign since_pb = now - pbegin_q;
	assign creq = (req_q.power_request > 8'd100) ? 7'd100 : req_q.power_request[6:0];
	assign limit = {3'd0, period_q[23:1]} + {2'd0, half_off_q} + {10'd0, pdly};

	// gate pin is driven by this tick
	logic wr_d;
	always_comb begin
		wr_d = 1'b0;
		if (req_q.operation == OP_TICK) begin
			unique case (phase_q)
				PH_IDLE:              wr_d = 1'b0;
				PH_WAIT1:             wr_d = since_last >= {7'd0, fdelay_q};
				PH_PULSE1, PH_PULSE2: wr_d = since_pb >= {8'd0, width_q};
				PH_WAIT2:             wr_d = {2'd0, since_last} >= limit;
				default:              wr_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; gate_q <= 1'b0; pend_q <= 1'b0; ramp_on_q <= 1'b0;
			power_q <= '0; rfrom_q <= '0; rto_q <= '0; last_q <= '0;
			period_q <= '0; pbegin_q <= '0; fdelay_q <= '0; rlen_q <= '0;
			rbegin_q <= '0; written_q <= 1'b0;
		end else if (cmd.exec) begin
			written_q <= wr_d;
			unique case (op_t'(req_q.operation))
				OP_CROSS: begin
					if (!(last_q != '0 && since_last < {8'd0, reject_q})) begin
						last_q <= now;
						if (last_q != '0) period_q <= since_last;
						pend_q <= 1'b1;
					end
				end
				OP_TICK: begin
					if (ramp_tick) begin
						if (ramp_cap) rbegin_q <= req_q.time_ms;
						else begin
							power_q <= pow_tick;
							if (ramp_end) ramp_on_q <= 1'b0;
						end
					end
					unique case (phase_q)
						PH_IDLE: if (pend_q) begin
							pend_q <= 1'b0;
							if (pow_tick != '0 && pow_tick >= minp_q) begin
								fdelay_q <= {1'b0, base_q} + {1'b0, pdly};
								phase_q <= PH_WAIT1;
							end
						end
						PH_WAIT1: if (since_last >= {7'd0, fdelay_q}) begin
							gate_q <= 1'b1;
							pbegin_q <= now; phase_q <= PH_PULSE1;
						end
						PH_PULSE1: if (since_pb >= {8'd0, width_q}) begin
							gate_q <= 1'b0;
							phase_q <= hmode_q ? PH_IDLE : PH_WAIT2;
						end
						PH_WAIT2: if ({2'd0, since_last} >= limit) begin
							gate_q <= 1'b1;
							pbegin_q <= now; phase_q <= PH_PULSE2;
						end
						PH_PULSE2: if (since_pb >= {8'd0, width_q}) begin
							gate_q <= 1'b0;
							phase_q <= PH_IDLE;
						end
						default: begin
							gate_q <= 1'b0;
							phase_q <= PH_IDLE;
						end
					endcase
				end
				OP_SET: power_q <= creq;
				OP_SET_RAMP: begin
					if (!(ramp_on_q && rto_q == creq)) begin
						if (req_q.ramp_ms == '0) begin
							ramp_on_q <= 1'b0; power_q <= creq;
						end else if (power_q == creq) begin
							ramp_on_q <= 1'b0;
						end else begin
							rfrom_q <= power_q; rto_q <= creq;
							rlen_q <= req_q.ramp_ms; rbegin_q <= '0;
							ramp_on_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.gate_level = gate_q;
	assign rsp.gate_written = written_q;
	assign rsp.power_now = power_q;
	assign rsp.period_us = period_q;
	assign rsp.fire_state = phase_q;
	assign rsp.ramp_running = ramp_on_q;

endmodule

FILE: sv/triac_phase_angle_controller.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_controller
// Zero-crossing timed triac gate firing with power ramp.
// ----------------------------------------------------------------------------
// in_ch carries one request: crossing, tick, set power or ramped set power.
// out_ch returns exactly one status word per request.
// cfg_we/cfg_idx/cfg_data write the seven registers; the user must do so only
// while the block is idle; the block does not enforce it. A request passes
// the divide, phase-delay and commit states before its result is valid; in the
// divide state a tick that advances a running ramp runs a restoring divider
// that loads the product and then settles one quotient bit a cycle over 23
// bits. One request is in flight at a time; the result is held in the output
// stage until taken and the next request is accepted the cycle after. Reset
// clears the config and controller registers and the firing state to idle;
// while the receiver stalls the result holds and no new request is accepted.
module triac_phase_angle_controller import tpac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	tpac_if.sink                in_ch,
	tpac_if.source              out_ch
);

	cmd_t cmd;
	sts_t sts;
	rsp_t rsp;

	tpac_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	tpac_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.req(in_ch.data), .cmd, .sts, .rsp
	);

	assign out_ch.data = rsp;

endmodule

FILE: sv/tpac_checker.sv
// ----------------------------------------------------------------------------
// tpac_checker
// Port-level checks of the controller handshake and result fields.
// ----------------------------------------------------------------------------
module tpac_checker import tpac_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request accepted with result pending");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_data))
		else $error("result dropped");

	a_power: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.power_now <= 7'd100) else $error("power out of range");

	a_written: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.gate_level && out_data.gate_written) |->
		(out_data.fire_state == PH_PULSE1 || out_data.fire_state == PH_PULSE2))
		else $error("gate high outside pulse");

endmodule

bind triac_phase_angle_controller tpac_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
